// ===== rtl/core/object_pool_allocator_core_assert.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef OBJECT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define OBJECT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define OPA_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define OPA_ASSERT_NXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== rtl/core/opa_pkg.sv =====
package opa_pkg;

	localparam int POOL_SIZE = 64;
	localparam int IDX_W = 6;
	localparam int OUT_W = 7;
	localparam int LW = $clog2(POOL_SIZE + 1);
	localparam int AW = $clog2(POOL_SIZE);
	localparam int CW = (LW > IDX_W) ? LW : IDX_W;

	typedef logic [LW-1:0] link_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cmp_t;

	localparam link_t NIL = link_t'(POOL_SIZE);

	typedef enum logic [1:0] {
		KIND_ACT_FRONT,
		KIND_ACT_BACK,
		KIND_DEACT,
		KIND_DEACT_ALL
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_EXHAUSTED,
		STAT_EMPTY,
		STAT_NOT_ACTIVE
	} status_t;

endpackage

// ===== rtl/core/opa_ram.sv =====
module opa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/object_pool_allocator_core.sv =====
// Object pool allocator. Issue an item with start while busy is low; the result appears for
// exactly one cycle with done high and cannot be stalled. Activate passes through S_ACT,
// deactivate of one slot through S_DEL1 and S_DEL2; an item rejected with exhausted pool or
// empty active list answers straight from S_IDLE. Deactivate-all walks the list in S_WALK,
// one list step per cycle. The link memories have a registered read and a single write
// port. Untouched slots are tracked by a fill count, so no clearing pass follows reset.
`include "object_pool_allocator_core_assert.svh"

module object_pool_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  kind,
	input  logic [opa_pkg::IDX_W-1:0]   member_index,
	output logic                        done,
	output logic [opa_pkg::OUT_W-1:0]   slot_index,
	output logic [1:0]                  status,
	output logic [opa_pkg::OUT_W-1:0]   active_count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACT,
		S_DEL1,
		S_DEL2,
		S_WALK
	} state_t;

	state_t          state_q;
	opa_pkg::link_t  fh_q;
	opa_pkg::link_t  head_q;
	opa_pkg::link_t  tail_q;
	opa_pkg::link_t  live_q;
	opa_pkg::link_t  fresh_q;
	opa_pkg::link_t  slot_q;
	opa_pkg::link_t  cur_q;
	opa_pkg::link_t  old_head_q;
	logic            fresh_hit_q;
	logic            front_link_q;
	logic            touched_q;

	logic                  nx_we, pv_we, pv_act;
	opa_pkg::addr_t        nx_waddr, pv_waddr, nx_raddr, idx_addr;
	opa_pkg::link_t        nx_wdata, pv_wdata, next_rd, prev_rd;
	logic [opa_pkg::LW:0]  pv_rd;
	logic                  act_rd;

	logic accept, is_act, fh_nil, list_empty, act_go, back_link, del_ok;

	// prev link and active flag share one entry
	assign prev_rd    = pv_rd[opa_pkg::LW-1:0];
	assign act_rd     = pv_rd[opa_pkg::LW];

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign is_act     = (kind == opa_pkg::KIND_ACT_FRONT) || (kind == opa_pkg::KIND_ACT_BACK);
	assign fh_nil     = (fh_q == opa_pkg::NIL);
	assign list_empty = (head_q == opa_pkg::NIL);
	assign act_go     = accept && is_act && !fh_nil;
	assign back_link  = act_go && (kind == opa_pkg::KIND_ACT_BACK) && !list_empty;
	assign del_ok     = (state_q == S_DEL1) && touched_q && act_rd;
	assign idx_addr   = opa_pkg::addr_t'(member_index);

	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = '0;
		nx_wdata = opa_pkg::NIL;
		pv_we    = 1'b0;
		pv_waddr = '0;
		pv_wdata = opa_pkg::NIL;
		pv_act   = 1'b0;
		case (kind)
			opa_pkg::KIND_DEACT:     nx_raddr = idx_addr;
			opa_pkg::KIND_DEACT_ALL: nx_raddr = opa_pkg::addr_t'(head_q);
			default:                 nx_raddr = opa_pkg::addr_t'(fh_q);
		endcase
		case (state_q)
			S_IDLE: begin
				if (act_go) begin
					pv_we    = 1'b1;
					pv_waddr = opa_pkg::addr_t'(fh_q);
					pv_wdata = back_link ? tail_q : opa_pkg::NIL;
					pv_act   = 1'b1;
				end
				if (back_link) begin
					nx_we    = 1'b1;
					nx_waddr = opa_pkg::addr_t'(tail_q);
					nx_wdata = fh_q;
				end
			end
			S_ACT: begin
				nx_we    = 1'b1;
				nx_waddr = opa_pkg::addr_t'(slot_q);
				nx_wdata = front_link_q ? old_head_q : opa_pkg::NIL;
				if (front_link_q) begin
					pv_we    = 1'b1;
					pv_waddr = opa_pkg::addr_t'(old_head_q);
					pv_wdata = slot_q;
					pv_act   = 1'b1;
				end
			end
			S_DEL1: begin
				if (del_ok) begin
					if (prev_rd != opa_pkg::NIL) begin
						nx_we    = 1'b1;
						nx_waddr = opa_pkg::addr_t'(prev_rd);
						nx_wdata = next_rd;
					end
					if (next_rd != opa_pkg::NIL) begin
						pv_we    = 1'b1;
						pv_waddr = opa_pkg::addr_t'(next_rd);
						pv_wdata = prev_rd;
						pv_act   = 1'b1;
					end
				end
			end
			S_DEL2: begin
				nx_we    = 1'b1;
				nx_waddr = opa_pkg::addr_t'(slot_q);
				nx_wdata = fh_q;
				pv_we    = 1'b1;
				pv_waddr = opa_pkg::addr_t'(slot_q);
			end
			S_WALK: begin
				nx_raddr = opa_pkg::addr_t'(next_rd);
				nx_we    = 1'b1;
				nx_waddr = opa_pkg::addr_t'(cur_q);
				nx_wdata = fh_q;
				pv_we    = 1'b1;
				pv_waddr = opa_pkg::addr_t'(cur_q);
			end
			default: begin
			end
		endcase
	end

	opa_ram #(.WIDTH(opa_pkg::LW), .DEPTH(opa_pkg::POOL_SIZE)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (next_rd)
	);

	opa_ram #(.WIDTH(opa_pkg::LW + 1), .DEPTH(opa_pkg::POOL_SIZE)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata ({pv_act, pv_wdata}),
		.raddr (idx_addr),
		.rdata (pv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fh_q         <= '0;
			head_q       <= opa_pkg::NIL;
			tail_q       <= opa_pkg::NIL;
			live_q       <= '0;
			fresh_q      <= '0;
			slot_q       <= '0;
			cur_q        <= '0;
			old_head_q   <= '0;
			fresh_hit_q  <= 1'b0;
			front_link_q <= 1'b0;
			touched_q    <= 1'b0;
			done         <= 1'b0;
			slot_index   <= '0;
			status       <= opa_pkg::STAT_OK;
			active_count <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_act) begin
							if (fh_nil) begin
								done         <= 1'b1;
								slot_index   <= opa_pkg::OUT_W'(opa_pkg::NIL);
								status       <= opa_pkg::STAT_EXHAUSTED;
								active_count <= opa_pkg::OUT_W'(live_q);
							end else begin
								slot_q       <= fh_q;
								fresh_hit_q  <= (fh_q == fresh_q);
								if (fh_q == fresh_q) begin
									fresh_q <= opa_pkg::link_t'(fresh_q + 1'b1);
								end
								front_link_q <= (kind == opa_pkg::KIND_ACT_FRONT) && !list_empty;
								old_head_q   <= head_q;
								live_q       <= opa_pkg::link_t'(live_q + 1'b1);
								if (list_empty) begin
									head_q <= fh_q;
									tail_q <= fh_q;
								end else if (kind == opa_pkg::KIND_ACT_FRONT) begin
									head_q <= fh_q;
								end else begin
									tail_q <= fh_q;
								end
								state_q <= S_ACT;
							end
						end else if (list_empty) begin
							done         <= 1'b1;
							slot_index   <= opa_pkg::OUT_W'(opa_pkg::NIL);
							status       <= opa_pkg::STAT_EMPTY;
							active_count <= opa_pkg::OUT_W'(live_q);
						end else if (kind == opa_pkg::KIND_DEACT) begin
							touched_q <= opa_pkg::cmp_t'(member_index) < opa_pkg::cmp_t'(fresh_q);
							slot_q    <= opa_pkg::link_t'(member_index);
							state_q   <= S_DEL1;
						end else begin
							cur_q   <= head_q;
							state_q <= S_WALK;
						end
					end
				end
				S_ACT: begin
					fh_q         <= fresh_hit_q ? opa_pkg::link_t'(slot_q + 1'b1) : next_rd;
					done         <= 1'b1;
					slot_index   <= opa_pkg::OUT_W'(slot_q);
					status       <= opa_pkg::STAT_OK;
					active_count <= opa_pkg::OUT_W'(live_q);
					state_q      <= S_IDLE;
				end
				S_DEL1: begin
					if (!del_ok) begin
						done         <= 1'b1;
						slot_index   <= opa_pkg::OUT_W'(opa_pkg::NIL);
						status       <= opa_pkg::STAT_NOT_ACTIVE;
						active_count <= opa_pkg::OUT_W'(live_q);
						state_q      <= S_IDLE;
					end else begin
						if (prev_rd == opa_pkg::NIL) begin
							head_q <= next_rd;
						end
						if (next_rd == opa_pkg::NIL) begin
							tail_q <= prev_rd;
						end
						live_q  <= opa_pkg::link_t'(live_q - 1'b1);
						state_q <= S_DEL2;
					end
				end
				S_DEL2: begin
					fh_q         <= slot_q;
					done         <= 1'b1;
					slot_index   <= opa_pkg::OUT_W'(slot_q);
					status       <= opa_pkg::STAT_OK;
					active_count <= opa_pkg::OUT_W'(live_q);
					state_q      <= S_IDLE;
				end
				S_WALK: begin
					fh_q   <= cur_q;
					live_q <= opa_pkg::link_t'(live_q - 1'b1);
					if (next_rd == opa_pkg::NIL) begin
						head_q       <= opa_pkg::NIL;
						tail_q       <= opa_pkg::NIL;
						done         <= 1'b1;
						slot_index   <= opa_pkg::OUT_W'(opa_pkg::NIL);
						status       <= opa_pkg::STAT_OK;
						active_count <= opa_pkg::OUT_W'(opa_pkg::link_t'(live_q - 1'b1));
						state_q      <= S_IDLE;
					end else begin
						cur_q <= next_rd;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`OPA_ASSERT_IMP(a_done_in_idle, done, state_q == S_IDLE)
	`OPA_ASSERT_IMP(a_empty_iff_zero, 1'b1, (head_q == opa_pkg::NIL) == (live_q == '0))
	`OPA_ASSERT_IMP(a_nofree_all_touched, fh_nil, fresh_q == opa_pkg::link_t'(opa_pkg::POOL_SIZE))
	`OPA_ASSERT_NXT(a_exhausted_result, accept && is_act && fh_nil, done && (status == opa_pkg::STAT_EXHAUSTED))

endmodule

// ===== bench/testbench.sv =====
module testbench;
	import opa_pkg::*;

	typedef logic [OUT_W-1:0] word_t;

	typedef struct {
		word_t   slot;
		status_t stat;
		word_t   count;
	} pool_reply_t;

	class pool_tracker;
		link_t       fwd[POOL_SIZE];
		link_t       back[POOL_SIZE];
		bit          in_use[POOL_SIZE];
		link_t       free_top;
		link_t       first;
		link_t       last;
		link_t       live;
		pool_reply_t due_replies[$];
		int          errors;

		function new();
			for (int i = 0; i < POOL_SIZE; i++) begin
				fwd[i] = link_t'(i + 1);
				back[i] = NIL;
				in_use[i] = 1'b0;
			end
			free_top = NIL;
			free_top = '0;
			first = NIL;
			last = NIL;
			live = '0;
			errors = 0;
		endfunction

		function void release_slot(link_t s);
			link_t p;
			link_t n;
			p = back[s];
			n = fwd[s];
			if (p == NIL && n == NIL) begin
				first = NIL;
				last = NIL;
			end else if (p == NIL) begin
				back[n] = NIL;
				first = n;
			end else if (n == NIL) begin
				fwd[p] = NIL;
				last = p;
			end else begin
				fwd[p] = n;
				back[n] = p;
			end
			back[s] = NIL;
			fwd[s] = free_top;
			if (free_top != NIL)
				back[free_top] = s;
			free_top = s;
			in_use[s] = 1'b0;
			if (live != 0)
				live--;
		endfunction

		function void apply_command(kind_t k, logic [IDX_W-1:0] idx);
			pool_reply_t r;
			link_t s;
			link_t cur;
			link_t nx;
			r.slot = NIL;
			r.stat = STAT_OK;
			case (k)
				KIND_ACT_FRONT, KIND_ACT_BACK: begin
					if (free_top == NIL) begin
						r.stat = STAT_EXHAUSTED;
					end else begin
						s = free_top;
						free_top = fwd[s];
						if (free_top != NIL)
							back[free_top] = NIL;
						back[s] = NIL;
						fwd[s] = NIL;
						in_use[s] = 1'b1;
						live++;
						if (first == NIL) begin
							first = s;
							last = s;
						end else if (k == KIND_ACT_FRONT) begin
							back[first] = s;
							fwd[s] = first;
							first = s;
						end else begin
							fwd[last] = s;
							back[s] = last;
							last = s;
						end
						r.slot = s;
					end
				end
				KIND_DEACT: begin
					if (first == NIL) begin
						r.stat = STAT_EMPTY;
					end else if (!in_use[idx]) begin
						r.stat = STAT_NOT_ACTIVE;
					end else begin
						release_slot(link_t'(idx));
						r.slot = link_t'(idx);
					end
				end
				default: begin
					if (first == NIL) begin
						r.stat = STAT_EMPTY;
					end else begin
						cur = first;
						for (int g = 0; g < POOL_SIZE && cur != NIL; g++) begin
							nx = fwd[cur];
							release_slot(cur);
							cur = nx;
						end
					end
				end
			endcase
			r.count = live;
			due_replies.push_back(r);
		endfunction

		// random active slot, or any index when none is active
		function logic [IDX_W-1:0] pick_active();
			link_t cur;
			int steps;
			if (live == 0)
				return IDX_W'($urandom_range(0, POOL_SIZE - 1));
			cur = first;
			steps = $urandom_range(0, live - 1);
			repeat (steps) cur = fwd[cur];
			return IDX_W'(cur);
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, what);
		endfunction

		function void check_reply(word_t slot, logic [1:0] stat, word_t count);
			pool_reply_t e;
			if (due_replies.size() == 0) begin
				flag($sformatf("unexpected result slot %0d status %0d count %0d",
					slot, stat, count));
				return;
			end
			e = due_replies.pop_front();
			if (slot !== e.slot)
				flag($sformatf("slot_index expected %0d got %0d", e.slot, slot));
			if (stat !== e.stat)
				flag($sformatf("status expected %0d got %0d", e.stat, stat));
			if (count !== e.count)
				flag($sformatf("active_count expected %0d got %0d", e.count, count));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       kind;
	logic [IDX_W-1:0] member_index;
	logic             done;
	word_t            slot_index;
	logic [1:0]       status;
	word_t            active_count;

	pool_tracker book;

	object_pool_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.member_index(member_index),
		.done(done),
		.slot_index(slot_index),
		.status(status),
		.active_count(active_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			book.check_reply(slot_index, status, active_count);
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic issue(kind_t k, logic [IDX_W-1:0] idx);
		start = 1'b1;
		kind = k;
		member_index = idx;
		do @(posedge clk); while (busy);
		book.apply_command(k, idx);
		@(negedge clk);
	endtask

	task automatic rest(bit burst);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (book.due_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_item(int act_permille, bit burst);
		int r;
		kind_t k;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(0, 999);
		idx = IDX_W'($urandom_range(0, POOL_SIZE - 1));
		if (r < act_permille)
			k = $urandom_range(0, 1) ? KIND_ACT_BACK : KIND_ACT_FRONT;
		else if (r >= 997)
			k = KIND_DEACT_ALL;
		else begin
			k = KIND_DEACT;
			if ($urandom_range(0, 4) != 0)
				idx = book.pick_active();
		end
		issue(k, idx);
		rest(burst);
	endtask

	initial begin
		int weights[8];
		weights = '{900, 600, 1000, 300, 990, 500, 850, 200};
		book = new();
		start = 1'b0;
		kind = KIND_ACT_FRONT;
		member_index = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list, front/back grants, inactive slot, head/middle/tail/only unlink, deactivate-all
		issue(KIND_DEACT, 6'd0);
		issue(KIND_DEACT_ALL, 6'd63);
		issue(KIND_ACT_FRONT, 6'd63);
		issue(KIND_ACT_BACK, 6'd0);
		issue(KIND_ACT_FRONT, 6'd42);
		issue(KIND_ACT_BACK, 6'd21);
		issue(KIND_DEACT, 6'd63);
		issue(KIND_DEACT, 6'd0);
		issue(KIND_DEACT, 6'd2);
		issue(KIND_DEACT, 6'd3);
		issue(KIND_DEACT, 6'd1);
		issue(KIND_DEACT, 6'd1);
		issue(KIND_ACT_FRONT, 6'd0);
		issue(KIND_ACT_BACK, 6'd63);
		issue(KIND_ACT_FRONT, 6'd0);
		issue(KIND_DEACT_ALL, 6'd0);
		issue(KIND_ACT_BACK, 6'd0);
		issue(KIND_DEACT_ALL, 6'd63);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 66; i++)
				random_item(weights[ph], ph % 3 == 1);
			drain();
		end

		repeat (80) @(posedge clk);
		book.errors += book.due_replies.size();
		if (book.errors == 0)
			$display("PASS object_pool_allocator_core");
		else
			$display("FAIL object_pool_allocator_core");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL object_pool_allocator_core");
		$finish;
	end

endmodule
